>>> rtl/masked_grid_triangulator_assert.svh
// Assertion macros shared by the triangulator modules.
`ifndef MASKED_GRID_TRIANGULATOR_ASSERT_SVH
`define MASKED_GRID_TRIANGULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MGT_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MGT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mgt_pkg.sv
`default_nettype none
package mgt_pkg;
    // Grid limits and derived widths
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WDIM_W      = COL_W + 1;
    localparam int HDIM_W      = ROW_W + 1;
    localparam int DIM_W       = 11;
    localparam int IDX_W       = 20;
    localparam int WIDTH_RST   = 640;
    localparam int HEIGHT_RST  = 480;
    localparam int JOB_Q_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

    // Triangle kinds, corner order as emitted
    typedef enum logic [1:0] {
        KIND_NW_NE_SE = 2'd0,
        KIND_NW_SE_SW = 2'd1,
        KIND_NW_NE_SW = 2'd2,
        KIND_NE_SE_SW = 2'd3
    } t_tri_kind;

    // One classified cell: its corners and one or two triangles
    typedef struct packed {
        logic [IDX_W-1:0] nw;
        logic [IDX_W-1:0] ne;
        logic [IDX_W-1:0] se;
        logic [IDX_W-1:0] sw;
        t_tri_kind        kind_a;
        t_tri_kind        kind_b;
        logic             two;
    } t_job;
endpackage
`default_nettype wire

>>> rtl/mgt_if.sv
`default_nettype none
// Pixel channel: one mask bit per beat
interface mgt_pix_if;
    logic valid;
    logic ready;
    logic masked_out;
    modport source (output valid, output masked_out, input ready);
    modport sink   (input valid, input masked_out, output ready);
endinterface

// Triangle channel: one triangle per beat
interface mgt_tri_if
    import mgt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] corner_first;
    logic [IDX_W-1:0] corner_second;
    logic [IDX_W-1:0] corner_third;
    logic [1:0]       triangle_kind;
    logic             last_of_run;
    modport source (output valid, output corner_first, output corner_second,
                    output corner_third, output triangle_kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input corner_first, input corner_second,
                    input corner_third, input triangle_kind, input last_of_run,
                    output ready);
endinterface

// Configuration write channel
interface mgt_cfg_if
    import mgt_pkg::*;
;
    logic             valid;
    logic             ready;
    t_cfg_reg         index;
    logic [DIM_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mgt_front.sv
`default_nettype none
module mgt_front
    import mgt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    mgt_pix_if.sink     i_pix,
    mgt_cfg_if.sink     i_cfg,
    output logic        o_job_valid,
    output t_job        o_job,
    input  wire         i_job_ready
);
    // Configuration registers
    logic [DIM_W-1:0]  r_gw, r_gh;
    logic [WDIM_W-1:0] w_eff;
    logic [HDIM_W-1:0] h_eff;

    // Position counters and left-neighbour bits
    logic [COL_W-1:0]  r_col, col_eff, n_col;
    logic [ROW_W-1:0]  r_row, row_eff, n_row;
    logic [IDX_W-1:0]  r_pix, pix_eff, n_pix;
    logic              r_left_cur, r_left_up;
    logic              restart;

    // Line store of the row above
    logic              r_store [MAX_WIDTH];
    logic              r_ne_m;

    // Classify stage
    logic              r_b_vld, r_b_se_m, r_b_emit;
    logic [IDX_W-1:0]  r_b_se, r_b_ne;
    logic              accept, b_done;
    logic              diag, anti, tri_a, tri_b;

    assign i_cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= DIM_W'(WIDTH_RST);
            r_gh <= DIM_W'(HEIGHT_RST);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GRID_WIDTH:  r_gw <= i_cfg.data;
                CFG_GRID_HEIGHT: r_gh <= i_cfg.data;
            endcase
        end
    end

    // Saturate geometry to the supported range
    always_comb begin
        if (32'(r_gw) < 32'd2)          w_eff = WDIM_W'(2);
        else if (32'(r_gw) > MAX_WIDTH) w_eff = WDIM_W'(MAX_WIDTH);
        else                            w_eff = WDIM_W'(r_gw);
        if (32'(r_gh) < 32'd2)           h_eff = HDIM_W'(2);
        else if (32'(r_gh) > MAX_HEIGHT) h_eff = HDIM_W'(MAX_HEIGHT);
        else                             h_eff = HDIM_W'(r_gh);
    end

    assign accept      = i_pix.valid && i_pix.ready;
    assign b_done      = r_b_vld && (!(tri_a || tri_b) || i_job_ready);
    assign i_pix.ready = !r_b_vld || b_done;

    // Restart the frame when the position lies past a shrunken grid
    always_comb begin
        restart = ({1'b0, r_col} >= w_eff) || ({1'b0, r_row} >= h_eff);
        col_eff = restart ? '0 : r_col;
        row_eff = restart ? '0 : r_row;
        pix_eff = restart ? '0 : r_pix;
        n_col   = col_eff + 1'b1;
        n_row   = row_eff;
        n_pix   = pix_eff + 1'b1;
        if ((WDIM_W'(col_eff) + 1'b1) >= w_eff) begin
            n_col = '0;
            if ((HDIM_W'(row_eff) + 1'b1) >= h_eff) begin
                n_row = '0;
                n_pix = '0;
            end else begin
                n_row = row_eff + 1'b1;
            end
        end
    end

    // Advance position on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_pix <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_pix <= n_pix;
        end
    end

    // Read the upper bit and replace it with the current one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ne_m           <= r_store[col_eff];
            r_store[col_eff] <= i_pix.masked_out;
        end
    end

    // Load the classify stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_se_m <= i_pix.masked_out;
            r_b_se   <= pix_eff;
            r_b_ne   <= pix_eff - IDX_W'(w_eff);
            r_b_emit <= (col_eff != '0) && (row_eff != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld    <= 1'b0;
            r_left_cur <= 1'b0;
            r_left_up  <= 1'b0;
        end else begin
            if (accept)      r_b_vld <= 1'b1;
            else if (b_done) r_b_vld <= 1'b0;
            if (b_done) begin
                r_left_up  <= r_ne_m;
                r_left_cur <= r_b_se_m;
            end
        end
    end

    // Classify the closed cell
    always_comb begin
        diag  = !r_left_up && !r_b_se_m;
        anti  = !r_ne_m && !r_left_cur;
        tri_a = 1'b0;
        tri_b = 1'b0;
        if (r_b_emit) begin
            if (diag) begin
                tri_a = !r_ne_m;
                tri_b = !r_left_cur;
            end else if (anti) begin
                tri_a = !r_left_up;
                tri_b = !r_b_se_m;
            end
        end
        o_job.se     = r_b_se;
        o_job.sw     = r_b_se - 1'b1;
        o_job.ne     = r_b_ne;
        o_job.nw     = r_b_ne - 1'b1;
        o_job.two    = tri_a && tri_b;
        o_job.kind_a = diag ? (tri_a ? KIND_NW_NE_SE : KIND_NW_SE_SW)
                            : (tri_a ? KIND_NW_NE_SW : KIND_NE_SE_SW);
        o_job.kind_b = diag ? KIND_NW_SE_SW : KIND_NE_SE_SW;
    end

    assign o_job_valid = r_b_vld && (tri_a || tri_b);
endmodule
`default_nettype wire

>>> rtl/mgt_queue.sv
`default_nettype none
module mgt_queue
    import mgt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_job   i_job,
    output logic        o_ready,
    output logic        o_valid,
    output t_job        o_job,
    input  wire         i_pop
);
`include "masked_grid_triangulator_assert.svh"
    localparam int PTR_W = $clog2(JOB_Q_DEPTH);
    localparam int CNT_W = $clog2(JOB_Q_DEPTH + 1);

    t_job             r_mem [JOB_Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_ready = r_count != CNT_W'(JOB_Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_job;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wr <= (32'(r_wr) == JOB_Q_DEPTH - 1) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (32'(r_rd) == JOB_Q_DEPTH - 1) ? '0 : r_rd + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    `MGT_ASSERT(a_q_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= JOB_Q_DEPTH,
                "queue overfilled")
    `MGT_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, push && !pop,
                     r_count == $past(r_count) + 1'b1, "queue count lost a beat")
endmodule
`default_nettype wire

>>> rtl/mgt_back.sv
`default_nettype none
module mgt_back
    import mgt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_job_valid,
    input  wire t_job   i_job,
    output logic        o_pop,
    mgt_tri_if.source   o_tri
);
`include "masked_grid_triangulator_assert.svh"
    t_job      r_job;
    logic      r_busy, r_second;
    logic      last, take;
    t_tri_kind kind;

    assign last  = !r_job.two || r_second;
    assign take  = !r_busy || (o_tri.ready && last);
    assign o_pop = take && i_job_valid;
    assign kind  = r_second ? r_job.kind_b : r_job.kind_a;

    // Select the corners of the current triangle
    always_comb begin
        unique case (kind)
            KIND_NW_NE_SE: begin
                o_tri.corner_first  = r_job.nw;
                o_tri.corner_second = r_job.ne;
                o_tri.corner_third  = r_job.se;
            end
            KIND_NW_SE_SW: begin
                o_tri.corner_first  = r_job.nw;
                o_tri.corner_second = r_job.se;
                o_tri.corner_third  = r_job.sw;
            end
            KIND_NW_NE_SW: begin
                o_tri.corner_first  = r_job.nw;
                o_tri.corner_second = r_job.ne;
                o_tri.corner_third  = r_job.sw;
            end
            KIND_NE_SE_SW: begin
                o_tri.corner_first  = r_job.ne;
                o_tri.corner_second = r_job.se;
                o_tri.corner_third  = r_job.sw;
            end
        endcase
    end

    assign o_tri.valid         = r_busy;
    assign o_tri.triangle_kind = kind;
    assign o_tri.last_of_run   = last;

    // Hold the current job
    always_ff @(posedge i_clk) begin
        if (take && i_job_valid) r_job <= i_job;
    end

    // Step through one or two triangles per job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (take) begin
            r_busy   <= i_job_valid;
            r_second <= 1'b0;
        end else if (o_tri.ready) begin
            r_second <= 1'b1;
        end
    end

    `MGT_ASSERT(a_second_pair, i_clk, i_rst_n, r_busy && r_second, r_job.two,
                "second triangle of a single-triangle cell")
    `MGT_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_busy && !o_tri.ready,
                     r_busy && $stable(r_second) && $stable(r_job),
                     "stalled triangle changed")
endmodule
`default_nettype wire

>>> rtl/masked_grid_triangulator.sv
// Path: classify stage, 4-entry job queue, back-end job register. Throughput:
// one pixel per cycle while pixels give at most one triangle and the queue
// has room; the output port sends one triangle per cycle while ready, so
// pixels with two triangles slow the input, the job queue absorbing bursts.
// Reset (synchronous, active low): counters, left bits and queue clear, width
// 640 and height 480; the line store is not cleared.
`default_nettype none
module masked_grid_triangulator
    import mgt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    mgt_pix_if.sink     i_pix,
    mgt_cfg_if.sink     i_cfg,
    mgt_tri_if.source   o_tri
);
    logic f_valid, q_ready, q_valid, b_pop;
    t_job f_job, q_job;

    mgt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (i_cfg),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (q_ready)
    );

    mgt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (b_pop)
    );

    mgt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (b_pop),
        .o_tri       (o_tri)
    );
endmodule
`default_nettype wire
